>>> src/wvgm_pkg.sv
// wvgm_pkg: shared field widths, register and action codes, bin entry type and
// the weight ROM entry function for the weighted vote group match unit.
// No dependencies.
`timescale 1ns / 1ps

package wvgm_pkg;

    localparam int ID_W       = 24;
    localparam int GROUP_W    = 11;
    localparam int COUNT_W    = 13;
    localparam int WEIGHT_W   = 32;
    localparam int NGROUPS_W  = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_GROUPS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_BASE    = 1'b1;

    // input item actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_VOTE = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [WEIGHT_W-1:0] weight;
    } bin_entry_t;

    // Rank weight for k = rank + 1: the largest m with (2m-1)^5 * k^3 <= 2^(5F+5),
    // i.e. round-half-up of 2^F * k^-0.6, saturated to 2^F - 1.
    // Only evaluated at elaboration.
    function automatic logic [31:0] rom_entry(input int unsigned k, input int unsigned frac);
        logic [191:0] acc;
        logic [191:0] target;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  mid;
        logic [31:0]  one;
        int unsigned  e;
        one    = 32'd1 << frac;
        lo     = 32'd0;
        hi     = one;
        e      = 5 * frac + 5;
        target = 192'd1 << e;
        for (int i = 0; i < 32; i++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 32'd1) >> 1);
                acc = 192'd1;
                for (int j = 0; j < 5; j++) begin
                    acc = acc * 192'((mid << 1) - 32'd1);
                end
                for (int j = 0; j < 3; j++) begin
                    acc = acc * 192'(k);
                end
                if (acc <= target) begin
                    lo = mid;
                end
                else begin
                    hi = mid - 32'd1;
                end
            end
        end
        return (lo > one - 32'd1) ? one - 32'd1 : lo;
    endfunction

endpackage

>>> src/wvgm_weight_rom.sv
// wvgm_weight_rom: rank weight table built at elaboration, registered read.
// Rank is clamped to the last entry. Depends on wvgm_pkg.
`timescale 1ns / 1ps

module wvgm_weight_rom
    import wvgm_pkg::*;
#(
    parameter int MAX_RUN          = 4096,
    parameter int WEIGHT_FRAC_BITS = 16
)
(
    input  logic                                  clk,
    input  logic [$clog2(MAX_RUN + 1)-1:0]        rank,
    output logic [WEIGHT_FRAC_BITS-1:0]           weight
);

    localparam int ROM_AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    logic [WEIGHT_FRAC_BITS-1:0] rom_table [MAX_RUN];
    logic [ROM_AW-1:0]           rom_addr;
    logic [WEIGHT_FRAC_BITS-1:0] weight_reg;

    for (genvar r = 0; r < MAX_RUN; r++) begin : g_rom
        localparam logic [WEIGHT_FRAC_BITS-1:0] ENTRY =
            WEIGHT_FRAC_BITS'(rom_entry(r + 1, WEIGHT_FRAC_BITS));
        assign rom_table[r] = ENTRY;
    end

    assign rom_addr = (32'(rank) >= MAX_RUN) ? ROM_AW'(MAX_RUN - 1) : rank[ROM_AW-1:0];

    always_ff @(posedge clk)
    begin
        weight_reg <= rom_table[rom_addr];
    end

    assign weight = weight_reg;

endmodule

>>> src/weighted_vote_group_match_unit.sv
// weighted_vote_group_match_unit: top level. Id-to-group map memory, bin memory
// with a forwarded read-modify-write pipeline, argmax scan and output register.
// Depends on wvgm_pkg and wvgm_weight_rom.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid/in_ready): action load writes the group of one
//   particle id into the map; action vote looks up the group and adds one to
//   its count and the rank weight to its weight. Ids outside
//   id_base+1 .. id_base+TABLE_DEPTH are dropped, and flagged for the run on a vote.
// - During a run one item is taken per cycle: a map read, then a bin read,
//   then the bin write-back, with the last write forwarded to the next read.
// - A vote item with last set closes the run. Input is held off through the
//   pipeline drain, then a scan of bins 0 .. num_groups (each bin read is
//   cleared as it goes), then the load of the result into the output
//   register, which raises out_valid; input opens again as it loads.
// - Output channel (out_valid/out_ready): one result item per run, held in
//   an output register. A new run may be fed while it waits; if its own
//   result is ready first, the block waits for the receiver before resuming.
// - Configuration channel (cfg_valid/cfg_ready) is always ready; write it only
//   while the block is idle.
// - After reset a clearing pass over max(TABLE_DEPTH, MAX_GROUPS+1) addresses sets
//   every map entry to background and every bin to zero; in_ready stays low
//   throughout.
module weighted_vote_group_match_unit
    import wvgm_pkg::*;
#(
    parameter int MAX_GROUPS       = 1024,
    parameter int TABLE_DEPTH      = 65536,
    parameter int MAX_RUN          = 4096,
    parameter int WEIGHT_FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input item channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic [ID_W-1:0]             particle_id,
    input  logic signed [GROUP_W-1:0]   group_id,
    input  logic                        last,
    // result item channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [GROUP_W-1:0]   best_group,
    output logic [COUNT_W-1:0]          shared_count,
    output logic                        bad_id_seen,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int NBINS    = MAX_GROUPS + 1;
    localparam int BIN_W    = $clog2(NBINS);
    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int RANK_W   = $clog2(MAX_RUN + 1);
    localparam int INIT_LEN = (TABLE_DEPTH > NBINS) ? TABLE_DEPTH : NBINS;
    localparam int INIT_CW  = $clog2(INIT_LEN);
    localparam int DIFF_W   = ID_W + 2;

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [INIT_CW-1:0]    init_cnt_reg;
    logic [NGROUPS_W-1:0]  num_groups_reg;
    logic [ID_W-1:0]       id_base_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic                  run_err_reg;
    logic                  res_err_reg;

    // vote pipeline
    logic                        s1_valid_reg, s1_ok_reg, s1_last_reg;
    logic                        s2_valid_reg, s2_ok_reg, s2_last_reg;
    logic [BIN_W-1:0]            s2_bin_reg;
    logic [WEIGHT_FRAC_BITS-1:0] s2_w_reg;
    logic                        fwd_valid_reg;
    logic [BIN_W-1:0]            fwd_bin_reg;
    bin_entry_t                  fwd_data_reg;

    // scan
    logic [BIN_W-1:0]      scan_addr_reg;
    logic                  scan_rd_valid_reg;
    logic [BIN_W-1:0]      scan_rd_bin_reg;
    logic [BIN_W-1:0]      best_bin_reg;
    logic [WEIGHT_W-1:0]   best_w_reg;
    logic [COUNT_W-1:0]    best_cnt_reg;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic signed [GROUP_W-1:0]   out_group_reg;
    logic [COUNT_W-1:0]          out_count_reg;
    logic                        out_err_reg;

    // memories
    logic [BIN_W-1:0]  map_mem [TABLE_DEPTH];
    logic [BIN_W-1:0]  map_q_reg;
    logic              map_we;
    logic [IDX_W-1:0]  map_addr;
    logic [BIN_W-1:0]  map_wd;

    bin_entry_t        bin_mem [NBINS];
    bin_entry_t        bin_q_reg;
    logic              bin_we;
    logic [BIN_W-1:0]  bin_wa;
    logic [BIN_W-1:0]  bin_ra;
    bin_entry_t        bin_wd;

    // combinational
    logic                        in_acc;
    logic                        vote_acc;
    logic                        close_run;
    logic [DIFF_W-1:0]           id_diff;
    logic                        id_ok;
    logic [BIN_W-1:0]            load_enc;
    logic [BIN_W-1:0]            ng;
    logic [BIN_W-1:0]            s1_bin;
    logic [WEIGHT_FRAC_BITS-1:0] rom_w;
    bin_entry_t                  old_entry;
    bin_entry_t                  new_entry;
    logic [WEIGHT_W:0]           w_sum;
    logic                        take;
    logic [BIN_W-1:0]            fin_bin;
    logic [WEIGHT_W-1:0]         fin_w;
    logic [COUNT_W-1:0]          fin_cnt;
    logic                        load_out;
    logic [31:0]                 group_wide;

    assign in_ready  = (state_reg == ST_RUN);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign vote_acc  = in_acc && (action == ACT_VOTE);
    assign close_run = vote_acc && last;

    // map index = particle_id - id_base - 1, valid below TABLE_DEPTH
    assign id_diff = DIFF_W'(particle_id) - DIFF_W'(id_base_reg) - DIFF_W'(1);
    assign id_ok   = !id_diff[DIFF_W-1] && (32'(id_diff[DIFF_W-2:0]) < TABLE_DEPTH);

    // stored code is group + 1, zero for background or any code out of range
    assign load_enc = (group_id[GROUP_W-1] || (32'(group_id[GROUP_W-2:0]) >= MAX_GROUPS))
                      ? '0 : BIN_W'(32'(group_id[GROUP_W-2:0]) + 32'd1);

    assign ng = (32'(num_groups_reg) > MAX_GROUPS) ? BIN_W'(MAX_GROUPS)
                                                   : BIN_W'(num_groups_reg);

    // groups beyond the current vote size count as background
    assign s1_bin = ((map_q_reg == '0) || (map_q_reg > ng)) ? '0 : map_q_reg;

    wvgm_weight_rom #(
        .MAX_RUN          (MAX_RUN),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_rom (
        .clk    (clk),
        .rank   (rank_reg),
        .weight (rom_w)
    );

    // ---------------- map memory: one port, read-first ----------------
    always_comb
    begin
        if (state_reg == ST_INIT) begin
            map_we   = (32'(init_cnt_reg) < TABLE_DEPTH);
            map_addr = init_cnt_reg[IDX_W-1:0];
            map_wd   = '0;
        end
        else begin
            map_we   = in_acc && (action == ACT_LOAD) && id_ok;
            map_addr = id_diff[IDX_W-1:0];
            map_wd   = load_enc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we) begin
            map_mem[map_addr] <= map_wd;
        end
        map_q_reg <= map_mem[map_addr];
    end

    // ---------------- bin update with forwarding ----------------
    // The previous write lands at the same edge as this item's read, so the
    // memory returns stale data on a hit; take it from the forward register.
    assign old_entry = (fwd_valid_reg && (fwd_bin_reg == s2_bin_reg)) ? fwd_data_reg
                                                                       : bin_q_reg;
    assign w_sum = {1'b0, old_entry.weight} + (WEIGHT_W + 1)'(s2_w_reg);

    always_comb
    begin
        new_entry.weight = w_sum[WEIGHT_W] ? {WEIGHT_W{1'b1}} : w_sum[WEIGHT_W-1:0];
        new_entry.count  = (old_entry.count == COUNT_MAX) ? old_entry.count
                                                          : old_entry.count + 1'b1;
    end

    always_comb
    begin
        case (state_reg)
            ST_INIT:
            begin
                bin_we = (32'(init_cnt_reg) < NBINS);
                bin_wa = init_cnt_reg[BIN_W-1:0];
                bin_wd = '0;
            end
            ST_SCAN:
            begin
                bin_we = 1'b1;
                bin_wa = scan_addr_reg;
                bin_wd = '0;
            end
            default:
            begin
                bin_we = s2_valid_reg && s2_ok_reg;
                bin_wa = s2_bin_reg;
                bin_wd = new_entry;
            end
        endcase
    end

    assign bin_ra = (state_reg == ST_SCAN) ? scan_addr_reg : s1_bin;

    always_ff @(posedge clk)
    begin
        if (bin_we) begin
            bin_mem[bin_wa] <= bin_wd;
        end
        bin_q_reg <= bin_mem[bin_ra];
    end

    // ---------------- argmax over scanned bins ----------------
    // strict compare keeps the lowest bin on ties; bin 0 seeds the search
    assign take = scan_rd_valid_reg
                  && ((scan_rd_bin_reg == '0) || (bin_q_reg.weight > best_w_reg));
    assign fin_bin = take ? scan_rd_bin_reg  : best_bin_reg;
    assign fin_w   = take ? bin_q_reg.weight : best_w_reg;
    assign fin_cnt = take ? bin_q_reg.count  : best_cnt_reg;

    assign load_out   = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign group_wide = 32'(fin_bin) - 32'd1;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (32'(init_cnt_reg) == INIT_LEN - 1) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (close_run) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (s2_valid_reg && s2_last_reg) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_addr_reg == ng) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (load_out) begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg         <= ST_INIT;
            init_cnt_reg      <= '0;
            num_groups_reg    <= '0;
            id_base_reg       <= '0;
            rank_reg          <= '0;
            run_err_reg       <= 1'b0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            fwd_valid_reg     <= 1'b0;
            scan_addr_reg     <= '0;
            scan_rd_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (state_reg == ST_INIT) begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NUM_GROUPS: num_groups_reg <= cfg_data[NGROUPS_W-1:0];
                    REG_ID_BASE:    id_base_reg    <= cfg_data[ID_W-1:0];
                    default:        ;
                endcase
            end

            // rank and error flag restart with the item after a closing vote
            if (vote_acc) begin
                if (last) begin
                    rank_reg    <= '0;
                    run_err_reg <= 1'b0;
                end
                else begin
                    if (32'(rank_reg) < MAX_RUN) begin
                        rank_reg <= rank_reg + 1'b1;
                    end
                    if (!id_ok) begin
                        run_err_reg <= 1'b1;
                    end
                end
            end

            s1_valid_reg  <= vote_acc;
            s2_valid_reg  <= s1_valid_reg;
            fwd_valid_reg <= (state_reg != ST_INIT) && (state_reg != ST_SCAN)
                             && s2_valid_reg && s2_ok_reg;

            scan_addr_reg     <= (state_reg == ST_SCAN) ? scan_addr_reg + 1'b1 : '0;
            scan_rd_valid_reg <= (state_reg == ST_SCAN);
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (close_run) begin
            res_err_reg <= run_err_reg || !id_ok;
        end
        s1_ok_reg       <= id_ok;
        s1_last_reg     <= last;
        s2_ok_reg       <= s1_ok_reg;
        s2_last_reg     <= s1_last_reg;
        s2_bin_reg      <= s1_bin;
        s2_w_reg        <= rom_w;
        fwd_bin_reg     <= s2_bin_reg;
        fwd_data_reg    <= new_entry;
        scan_rd_bin_reg <= scan_addr_reg;
        best_bin_reg    <= fin_bin;
        best_w_reg      <= fin_w;
        best_cnt_reg    <= fin_cnt;
        if (load_out) begin
            out_group_reg <= GROUP_W'(group_wide);
            out_count_reg <= fin_cnt;
            out_err_reg   <= res_err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign best_group   = out_group_reg;
    assign shared_count = out_count_reg;
    assign bad_id_seen  = out_err_reg;

endmodule

>>> src/wvgm_checker.sv
// wvgm_checker: port-level assertions for the weighted vote group match unit,
// bound to the top level. Depends on wvgm_pkg.
`timescale 1ns / 1ps

module wvgm_checker
    import wvgm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        action,
    input  logic                        last,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [GROUP_W-1:0]   best_group,
    input  logic [COUNT_W-1:0]          shared_count,
    input  logic                        bad_id_seen
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(best_group)
                                    && $stable(shared_count) && $stable(bad_id_seen))
        else $error("result item changed while stalled");

    // closing vote stops input for the drain and scan
    a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == ACT_VOTE) && last |=> !in_ready)
        else $error("input taken straight after a closing vote");

    // a new result only appears out of the scan, with input held off
    a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while input was open");

    // an empty winner means nothing was weighted, so background won
    a_empty_is_background: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (shared_count == '0) |-> (best_group == {GROUP_W{1'b1}}))
        else $error("empty winning bin is not background");

endmodule

bind weighted_vote_group_match_unit wvgm_checker u_wvgm_checker (.*);
